/* src/crcfr_pkg.sv */
// ----------------------------------------------------------------------------
// crcfr_pkg: shared types and constants of the CRC-8 frame receiver
// Holds the frame parser phases, the command word passed from the front part
// to the back part, the status codes and the reflected CRC-8 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package crcfr_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] TERM_BYTE = 8'h0A;
    localparam logic [7:0] CRC_POLY  = 8'h8C;
    localparam logic [7:0] CRC_INIT  = 8'h00;
    localparam logic [7:0] ACK_RESET = 8'h06;
    localparam logic [7:0] SIZE_MAX  = 8'(MAX_PAYLOAD + 1);

    typedef enum logic [2:0] {
        PH_CRC  = 3'd0,
        PH_SIZE = 3'd1,
        PH_DATA = 3'd2,
        PH_TERM = 3'd3,
        PH_SKIP = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_CRC  = 2'd1,
        ST_LEN  = 2'd2,
        ST_TERM = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_CRC      = 3'd0,
        CMD_SIZE     = 3'd1,
        CMD_DATA     = 3'd2,
        CMD_TERM     = 3'd3,
        CMD_BAD_TERM = 3'd4,
        CMD_BAD_LEN  = 3'd5
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    function automatic logic [7:0] crc_step(input logic [7:0] crc_in, input logic [7:0] b_in);
        logic [7:0] crc;
        logic [7:0] b;
        logic       fb;
        crc = crc_in;
        b   = b_in;
        for (int i = 0; i < 8; i++)
        begin
            fb  = crc[0] ^ b[0];
            crc = crc >> 1;
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
            b = b >> 1;
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

/* src/crcfr_front.sv */
// ----------------------------------------------------------------------------
// crcfr_front: frame parser
// Tracks the frame phase and payload count for each received byte and turns
// every byte that matters into a command for the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_front
    import crcfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] rx_byte,
    output logic            push,
    output cmd_t            cmd
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;
    logic       bad_size;

    assign bad_size = (rx_byte == 8'd0) || (rx_byte > SIZE_MAX);

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        case (phase_reg)
            PH_SIZE:
            begin
                if (bad_size)
                begin
                    phase_next = PH_SKIP;
                end
                else
                begin
                    bytes_left_next = rx_byte - 8'd1;
                    phase_next      = (rx_byte == 8'd1) ? PH_TERM : PH_DATA;
                end
            end
            PH_DATA:
            begin
                bytes_left_next = bytes_left_reg - 8'd1;
                if (bytes_left_reg == 8'd1)
                begin
                    phase_next = PH_TERM;
                end
            end
            PH_TERM:
            begin
                phase_next = (rx_byte == TERM_BYTE) ? PH_CRC : PH_SKIP;
            end
            PH_SKIP:
            begin
                if (rx_byte == TERM_BYTE)
                begin
                    phase_next = PH_CRC;
                end
            end
            default:
            begin
                bytes_left_next = 8'd0;
                phase_next      = PH_SIZE;
            end
        endcase
    end

    always_comb
    begin
        push     = accept;
        cmd.data = rx_byte;
        case (phase_reg)
            PH_SIZE: cmd.kind = bad_size ? CMD_BAD_LEN : CMD_SIZE;
            PH_DATA: cmd.kind = CMD_DATA;
            PH_TERM: cmd.kind = (rx_byte == TERM_BYTE) ? CMD_TERM : CMD_BAD_TERM;
            PH_SKIP:
            begin
                cmd.kind = CMD_CRC;
                push     = 1'b0;
            end
            default: cmd.kind = CMD_CRC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_CRC;
            bytes_left_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

`default_nettype wire

/* src/crcfr_queue.sv */
// ----------------------------------------------------------------------------
// crcfr_queue: command queue
// Short first-in first-out buffer that lets the parser and the CRC back part
// stall independently of each other.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_queue
    import crcfr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      head_cmd
);

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* src/crcfr_back.sv */
// ----------------------------------------------------------------------------
// crcfr_back: CRC engine and result register
// Executes parser commands: keeps the received and running CRC, forwards
// payload bytes and builds the frame verdict in a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_back
    import crcfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] ack_code,
    input  wire logic       cmd_valid,
    input  wire cmd_t       cmd,
    output logic            cmd_pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            payload_valid,
    output logic            frame_end,
    output status_t         status,
    output logic            send_ack
);

    logic [7:0] expected_crc_reg;
    logic [7:0] expected_crc_next;
    logic [7:0] running_crc_reg;
    logic [7:0] running_crc_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       payload_reg;
    logic       payload_next;
    logic       frame_end_reg;
    logic       frame_end_next;
    status_t    status_reg;
    status_t    status_next;
    logic       send_ack_reg;
    logic       send_ack_next;
    logic       has_result;

    assign cmd_pop = cmd_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        expected_crc_next = expected_crc_reg;
        running_crc_next  = running_crc_reg;
        has_result        = 1'b0;
        out_byte_next     = ack_code;
        payload_next      = 1'b0;
        frame_end_next    = 1'b0;
        status_next       = ST_OK;
        send_ack_next     = 1'b0;
        case (cmd.kind)
            CMD_CRC:
            begin
                expected_crc_next = cmd.data;
                running_crc_next  = CRC_INIT;
            end
            CMD_SIZE:
            begin
                running_crc_next = crc_step(CRC_INIT, cmd.data);
            end
            CMD_DATA:
            begin
                running_crc_next = crc_step(running_crc_reg, cmd.data);
                has_result       = 1'b1;
                out_byte_next    = cmd.data;
                payload_next     = 1'b1;
            end
            CMD_TERM:
            begin
                has_result     = 1'b1;
                frame_end_next = 1'b1;
                if (running_crc_reg == expected_crc_reg)
                begin
                    send_ack_next = 1'b1;
                end
                else
                begin
                    status_next = ST_CRC;
                end
            end
            CMD_BAD_TERM:
            begin
                has_result     = 1'b1;
                frame_end_next = 1'b1;
                status_next    = ST_TERM;
            end
            CMD_BAD_LEN:
            begin
                has_result     = 1'b1;
                frame_end_next = 1'b1;
                status_next    = ST_LEN;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd_pop)
        begin
            out_valid_next = has_result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            expected_crc_reg <= CRC_INIT;
            running_crc_reg  <= CRC_INIT;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd_pop)
            begin
                expected_crc_reg <= expected_crc_next;
                running_crc_reg  <= running_crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && has_result)
        begin
            out_byte_reg  <= out_byte_next;
            payload_reg   <= payload_next;
            frame_end_reg <= frame_end_next;
            status_reg    <= status_next;
            send_ack_reg  <= send_ack_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign payload_valid = payload_reg;
    assign frame_end     = frame_end_reg;
    assign status        = status_reg;
    assign send_ack      = send_ack_reg;

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (payload_reg ^ frame_end_reg))
        else $error("result is neither a payload byte nor a verdict");

    a_ack_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && send_ack_reg |-> frame_end_reg && (status_reg == ST_OK))
        else $error("ack requested on a frame that is not good");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && payload_reg |-> (status_reg == ST_OK) && !send_ack_reg)
        else $error("payload result carries verdict bits");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !cmd_pop)
        else $error("command taken while a result is stalled");

endmodule

`default_nettype wire

/* src/crc8_frame_receiver.sv */
// ----------------------------------------------------------------------------
// crc8_frame_receiver: framed byte receiver with CRC-8 check
// Bytes arrive on the s_ stream as frames [crc][size][payload][newline]; the
// m_ stream carries one result per payload byte and one verdict per frame.
//
// Usage notes:
// The s_ channel takes one received byte per request in s_tdata[7:0]. The m_
// channel returns payload bytes (m_tuser high) and frame verdicts (m_tlast
// high); a verdict holds the status and the ack byte in the data field and,
// on a good frame, send_ack. The cfg channel writes the ack byte and is
// always ready; write it only while no frame is in flight.
// The byte that causes a result enters the command queue when it is accepted
// and the CRC unit moves it into the output register once that register is
// free or being read. While the m_ side does not stall, the block sustains
// one byte per cycle, a rate set by the combinational eight-bit CRC update.
// When the m_ side stalls, the two-entry command queue absorbs the bytes in
// flight and s_tready falls once it is full. Reset returns the parser to
// waiting for a CRC byte, clears both CRC registers, empties the queue and
// the output register, and restores the ack byte to 0x06.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_frame_receiver
    import crcfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,     // [7:0] out_byte, [9:8] status, [10] send_ack
    output logic             m_tuser,     // [0] payload_valid
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);

    logic [7:0] ack_code_reg;
    logic       accept;
    logic       push;
    cmd_t       push_cmd;
    logic       q_full;
    logic       q_valid;
    cmd_t       head_cmd;
    logic       pop;
    logic [7:0] out_byte;
    status_t    status;
    logic       send_ack;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_code_reg <= ACK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ack_code_reg <= cfg_data;
        end
    end

    crcfr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_tdata),
        .push    (push),
        .cmd     (push_cmd)
    );

    crcfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .head_cmd  (head_cmd)
    );

    crcfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .ack_code      (ack_code_reg),
        .cmd_valid     (q_valid),
        .cmd           (head_cmd),
        .cmd_pop       (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_byte      (out_byte),
        .payload_valid (m_tuser),
        .frame_end     (m_tlast),
        .status        (status),
        .send_ack      (send_ack)
    );

    assign m_tdata = {5'd0, send_ack, status, out_byte};

endmodule

`default_nettype wire
